// File: rtl/gsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared types and fixed field widths for the generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

    // fixed port widths
    localparam int IDX_W   = 10;
    localparam int GENP_W  = 32;
    localparam int FENCE_W = 64;
    localparam int CFG_W   = 11;
    localparam int OP_W    = 3;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INIT    = 3'd0,
        OP_ALLOC   = 3'd1,
        OP_RETIRE  = 3'd2,
        OP_COLLECT = 3'd3,
        OP_ALIVE   = 3'd4
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ALLOC_RD,
        S_ALLOC_GEN,
        S_CHECK,
        S_COL_EVAL,
        S_COL_COPY
    } t_state;

endpackage

// File: rtl/generational_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// generational_slot_allocator
// Hands out index plus generation handles from a free stack, retires them
// with a fence and returns them to the free stack when the fence completes.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------
//  command  | i_opcode i_slot_index i_slot_generation i_fence| i_start, o_busy
//  result   | o_ok o_out_index o_out_generation               | o_valid strobe
//           | o_allocated_count                             |
//  config   | i_cfg_data (capacity)                         | i_cfg_we
//
//  allocate pops the free stack, reads the slot and marks it. retire and
//  is_alive read the slot, then check the handle. collect walks the retired
//  list from the top, freeing entries whose fence has completed. all three
//  memories have registered reads; one read-modify-write runs at a time.
//  reset clears control state only; no clearing pass, the tables are written
//  by initialize before they are read.
//  the receiver cannot stall; o_valid is high for one cycle per word.
// ----------------------------------------------------------------------------
module generational_slot_allocator
    import gsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024,
    parameter int GEN_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [IDX_W-1:0]   i_slot_index,
    input  logic [GENP_W-1:0]  i_slot_generation,
    input  logic [FENCE_W-1:0] i_fence,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_valid,
    output logic               o_ok,
    output logic [IDX_W-1:0]   o_out_index,
    output logic [GENP_W-1:0]  o_out_generation,
    output logic [CFG_W-1:0]   o_allocated_count
);

    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = SLOT_W + 1;
    localparam int GW_W   = GEN_WIDTH + 1;
    localparam int RW_W   = FENCE_W + SLOT_W;

    // memories: slot word is {allocated mark, generation}
    logic [GW_W-1:0]   gen_mem [MAX_SLOTS];
    logic [SLOT_W-1:0] fs_mem  [MAX_SLOTS];
    logic [RW_W-1:0]   ret_mem [MAX_SLOTS];

    logic              gen_we, fs_we, ret_we;
    logic [SLOT_W-1:0] gen_waddr, fs_waddr, ret_waddr;
    logic [SLOT_W-1:0] gen_raddr, fs_raddr, ret_raddr;
    logic [GW_W-1:0]   gen_wdata;
    logic [SLOT_W-1:0] fs_wdata;
    logic [RW_W-1:0]   ret_wdata;
    logic [GW_W-1:0]   r_gen_rdata;
    logic [SLOT_W-1:0] r_fs_rdata;
    logic [RW_W-1:0]   r_ret_rdata;

    // control and payload registers
    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cap;
    logic [CNT_W-1:0]   r_tsize, n_tsize;
    logic [CNT_W-1:0]   r_free_top, n_free_top;
    logic [CNT_W-1:0]   r_ret_cnt, n_ret_cnt;
    logic [CNT_W-1:0]   r_live, n_live;
    logic [SLOT_W-1:0]  r_i, n_i;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [GENP_W-1:0]  r_hgen, n_hgen;
    logic [FENCE_W-1:0] r_fence, n_fence;
    logic               r_pre, n_pre;
    logic               r_retire, n_retire;
    logic               r_valid, n_valid;
    logic               r_ok, n_ok;
    logic [SLOT_W-1:0]  r_oidx, n_oidx;
    logic [GEN_WIDTH-1:0] r_ogen, n_ogen;

    // decoded helpers
    logic [CNT_W-1:0]     init_n;
    logic                 idx_pre;
    logic                 hit;
    logic [GEN_WIDTH-1:0] gen_next;
    logic [FENCE_W-1:0]   ent_fence;
    logic [SLOT_W-1:0]    ent_slot;

    assign init_n = (32'(r_cap) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : CNT_W'(r_cap);
    assign idx_pre = (i_slot_generation != '0) &&
                     (32'(i_slot_index) < 32'(r_tsize));
    assign hit = r_pre && r_gen_rdata[GEN_WIDTH] &&
                 (GENP_W'(r_gen_rdata[GEN_WIDTH-1:0]) == r_hgen);
    assign gen_next = (r_gen_rdata[GEN_WIDTH-1:0] + 1'b1 == '0) ?
                      GEN_WIDTH'(1) : r_gen_rdata[GEN_WIDTH-1:0] + 1'b1;
    assign ent_fence = r_ret_rdata[SLOT_W +: FENCE_W];
    assign ent_slot  = r_ret_rdata[SLOT_W-1:0];

    // memory ports
    always_ff @(posedge i_clk) begin
        if (gen_we) begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        r_gen_rdata <= gen_mem[gen_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            fs_mem[fs_waddr] <= fs_wdata;
        end
        r_fs_rdata <= fs_mem[fs_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (ret_we) begin
            ret_mem[ret_waddr] <= ret_wdata;
        end
        r_ret_rdata <= ret_mem[ret_raddr];
    end

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CFG_W'(1024);
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tsize    <= '0;
            r_free_top <= '0;
            r_ret_cnt  <= '0;
            r_live     <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tsize    <= n_tsize;
            r_free_top <= n_free_top;
            r_ret_cnt  <= n_ret_cnt;
            r_live     <= n_live;
            r_valid    <= n_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_slot   <= n_slot;
        r_hgen   <= n_hgen;
        r_fence  <= n_fence;
        r_pre    <= n_pre;
        r_retire <= n_retire;
        r_ok     <= n_ok;
        r_oidx   <= n_oidx;
        r_ogen   <= n_ogen;
    end

    // sequencer: next state, memory controls and result word
    always_comb begin
        n_state    = r_state;
        n_tsize    = r_tsize;
        n_free_top = r_free_top;
        n_ret_cnt  = r_ret_cnt;
        n_live     = r_live;
        n_i        = r_i;
        n_slot     = r_slot;
        n_hgen     = r_hgen;
        n_fence    = r_fence;
        n_pre      = r_pre;
        n_retire   = r_retire;
        n_valid    = 1'b0;
        n_ok       = r_ok;
        n_oidx     = r_oidx;
        n_ogen     = r_ogen;
        gen_we     = 1'b0;
        gen_waddr  = '0;
        gen_wdata  = '0;
        gen_raddr  = '0;
        fs_we      = 1'b0;
        fs_waddr   = '0;
        fs_wdata   = '0;
        fs_raddr   = '0;
        ret_we     = 1'b0;
        ret_waddr  = '0;
        ret_wdata  = '0;
        ret_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ok   = 1'b0;
                    n_oidx = '0;
                    n_ogen = '0;
                    unique case (t_op'(i_opcode))
                        OP_INIT: begin
                            n_tsize    = init_n;
                            n_free_top = init_n;
                            n_ret_cnt  = '0;
                            n_live     = '0;
                            n_i        = '0;
                            n_state    = S_INIT;
                        end
                        OP_ALLOC: begin
                            if (r_free_top != '0) begin
                                fs_raddr   = SLOT_W'(r_free_top - 1'b1);
                                n_free_top = r_free_top - 1'b1;
                                n_state    = S_ALLOC_RD;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        OP_RETIRE, OP_ALIVE: begin
                            gen_raddr = SLOT_W'(i_slot_index);
                            n_slot    = SLOT_W'(i_slot_index);
                            n_hgen    = i_slot_generation;
                            n_fence   = i_fence;
                            n_retire  = (t_op'(i_opcode) == OP_RETIRE);
                            n_pre     = idx_pre && ((t_op'(i_opcode) == OP_ALIVE) ||
                                        (32'(r_ret_cnt) < 32'(MAX_SLOTS)));
                            n_state   = S_CHECK;
                        end
                        OP_COLLECT: begin
                            if (r_ret_cnt != '0) begin
                                ret_raddr = SLOT_W'(r_ret_cnt - 1'b1);
                                n_i       = SLOT_W'(r_ret_cnt - 1'b1);
                                n_fence   = i_fence;
                                n_state   = S_COL_EVAL;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            // sweep: every slot to generation 1 unmarked, fill free stack
            S_INIT: begin
                gen_we    = 1'b1;
                gen_waddr = r_i;
                gen_wdata = GW_W'(1);
                if (CNT_W'(r_i) < r_tsize) begin
                    fs_we    = 1'b1;
                    fs_waddr = r_i;
                    fs_wdata = SLOT_W'(r_tsize - 1'b1 - CNT_W'(r_i));
                end
                if (r_i == SLOT_W'(MAX_SLOTS - 1)) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            // popped slot arrives, fetch its generation
            S_ALLOC_RD: begin
                gen_raddr = r_fs_rdata;
                n_slot    = r_fs_rdata;
                n_state   = S_ALLOC_GEN;
            end

            // mark allocated and report
            S_ALLOC_GEN: begin
                gen_we    = 1'b1;
                gen_waddr = r_slot;
                gen_wdata = {1'b1, r_gen_rdata[GEN_WIDTH-1:0]};
                n_live    = r_live + 1'b1;
                n_ok      = 1'b1;
                n_oidx    = r_slot;
                n_ogen    = r_gen_rdata[GEN_WIDTH-1:0];
                n_valid   = 1'b1;
                n_state   = S_IDLE;
            end

            // handle check, retire updates slot and queues it
            S_CHECK: begin
                n_ok = hit;
                if (hit && r_retire) begin
                    gen_we    = 1'b1;
                    gen_waddr = r_slot;
                    gen_wdata = {1'b0, gen_next};
                    ret_we    = 1'b1;
                    ret_waddr = SLOT_W'(r_ret_cnt);
                    ret_wdata = {r_fence, r_slot};
                    n_ret_cnt = r_ret_cnt + 1'b1;
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end
                n_valid = 1'b1;
                n_state = S_IDLE;
            end

            // retired entry arrives, free it if its fence has completed
            S_COL_EVAL: begin
                if (ent_fence > r_fence) begin
                    if (r_i == '0) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        ret_raddr = r_i - 1'b1;
                        n_i       = r_i - 1'b1;
                    end
                end else begin
                    if (32'(r_free_top) < 32'(MAX_SLOTS)) begin
                        fs_we      = 1'b1;
                        fs_waddr   = SLOT_W'(r_free_top);
                        fs_wdata   = ent_slot;
                        n_free_top = r_free_top + 1'b1;
                    end
                    n_ret_cnt = r_ret_cnt - 1'b1;
                    ret_raddr = SLOT_W'(r_ret_cnt - 1'b1);
                    n_state   = S_COL_COPY;
                end
            end

            // move last entry into the freed place
            S_COL_COPY: begin
                ret_we    = 1'b1;
                ret_waddr = r_i;
                ret_wdata = r_ret_rdata;
                if (r_i == '0) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    ret_raddr = r_i - 1'b1;
                    n_i       = r_i - 1'b1;
                    n_state   = S_COL_EVAL;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    assign o_busy            = (r_state != S_IDLE);
    assign o_valid           = r_valid;
    assign o_ok              = r_ok;
    assign o_out_index       = IDX_W'(r_oidx);
    assign o_out_generation  = GENP_W'(r_ogen);
    assign o_allocated_count = CFG_W'(r_live);

`ifndef SYNTH
    a_live_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_tsize)
        else $error("live count above table size");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_free_top) <= 32'(MAX_SLOTS)) && (32'(r_ret_cnt) <= 32'(MAX_SLOTS)))
        else $error("free stack or retired list overflow");

    a_finish_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && n_state == S_IDLE) |=> r_valid)
        else $error("operation finished without result word");

    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && t_op'(i_opcode) == OP_INIT) |=> !r_valid)
        else $error("initialize reported before sweep");
`endif

endmodule
